>>> rtl/adrc_pkg.sv
// ----------------------------------------------------------------------------
// adrc_pkg
// Shared widths, constants and controller/datapath types for the compressor.
// ----------------------------------------------------------------------------
package adrc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ENV_W    = 16;
    localparam int THR_W    = 15;
    localparam int MAKEUP_W = 14;
    localparam int GAIN_W   = 15;
    localparam int TSET_W   = 10;
    localparam int MSET_W   = 15;
    localparam int MIX_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
    localparam cfg_idx_t CFG_MAKEUP    = 2'd1;
    localparam cfg_idx_t CFG_WET_MIX   = 2'd2;

    localparam int THR_SET_MAX   = 1000;
    localparam int MAKEUP_SET_MAX = 32000;
    localparam int MIX_MAX       = 32000;
    localparam int MIX_FULL      = 32767;

    localparam int THR_SET_RESET    = 420;
    localparam int MAKEUP_SET_RESET = 6000;
    localparam int MIX_RESET        = 32000;

    localparam int THR_BASE  = 2048;
    localparam int THR_SCALE = 22000 / 1000;
    localparam int THR_RESET = THR_BASE + THR_SET_RESET * THR_SCALE;

    // setting*8192/32000 done as a multiply by ceil(2^34/32000) and a shift;
    // the rounding error stays below one code over the clamped range
    localparam int MAKEUP_BASE  = 4096;
    localparam int MAKEUP_SHIFT = 21;
    localparam int MAKEUP_RECIP_W = 20;
    localparam longint unsigned MAKEUP_RECIP =
        ((64'd8192 << MAKEUP_SHIFT) + 64'd31999) / 64'd32000;
    localparam int MAKEUP_RESET = MAKEUP_BASE + (MAKEUP_SET_RESET * 8192) / 32000;

    localparam int GAIN_UNITY = 32767;
    localparam int GAIN_FRAC  = 15;
    localparam int MAKEUP_FRAC = 12;
    localparam int MIX_FRAC   = 15;
    localparam int DIV_STEPS  = GAIN_FRAC;

    typedef struct packed {
        logic capture;
        logic env_mul;
        logic env_upd;
        logic gain_init;
        logic div_step;
        logic mul_gain;
        logic mul_makeup;
        logic mul_dry;
        logic mac_wet;
        logic load_out;
    } adrc_cmd_t;

    typedef struct packed {
        logic above;
    } adrc_stat_t;

endpackage

>>> rtl/adrc_if.sv
// ----------------------------------------------------------------------------
// adrc_if
// Request channels of the compressor: dry samples, results, register writes.
// ----------------------------------------------------------------------------
interface adrc_sample_if
    import adrc_pkg::*;
    ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;

    modport source (output valid, sample_in, last_in, input ready);
    modport sink   (input valid, sample_in, last_in, output ready);

endinterface

interface adrc_result_if
    import adrc_pkg::*;
    ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;

    modport source (output valid, sample_out, last_out, input ready);
    modport sink   (input valid, sample_out, last_out, output ready);

endinterface

interface adrc_cfg_if
    import adrc_pkg::*;
    ();

    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

>>> rtl/audio_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor
// Feed-forward 4:1 compressor with peak envelope, makeup gain and dry/wet mix.
// One signed 16-bit sample goes in per request and one saturated sample comes
// out, carrying its last flag. The next sample is accepted only once the
// previous result has been loaded into the output register; above the
// threshold the sample also passes the 15 iterations of the restoring gain
// divider. A finished result waits in the output register while the next
// sample is taken. Register writes are accepted on every cycle and belong
// between samples, once the last result has been delivered.
// ----------------------------------------------------------------------------
module audio_dynamic_range_compressor
    import adrc_pkg::*;
#(
    parameter int ATTACK_DIVISOR  = 8,
    parameter int RELEASE_DIVISOR = 128
)
(
    input logic          clk,
    input logic          rst_n,
    adrc_sample_if.sink  sample_ch,
    adrc_result_if.source result_ch,
    adrc_cfg_if.sink     cfg_ch
);

    adrc_cmd_t  cmd;
    adrc_stat_t stat;

    assign cfg_ch.ready = 1'b1;

    adrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    adrc_datapath #(
        .ATTACK_DIVISOR  (ATTACK_DIVISOR),
        .RELEASE_DIVISOR (RELEASE_DIVISOR)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_ch.valid),
        .cfg_index  (cfg_ch.index),
        .cfg_data   (cfg_ch.data),
        .sample_in  (sample_ch.sample_in),
        .last_in    (sample_ch.last_in),
        .sample_out (result_ch.sample_out),
        .last_out   (result_ch.last_out),
        .cmd        (cmd),
        .stat       (stat)
    );

    // only one datapath step per cycle
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture == (sample_ch.valid && sample_ch.ready))
        else $error("sample capture out of step with request acceptance");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
        else $error("second sample accepted while one is in progress");

    // never overwrite a result that has not been taken
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_ch.valid || result_ch.ready))
        else $error("output register loaded over a pending result");

endmodule

>>> rtl/adrc_datapath.sv
// ----------------------------------------------------------------------------
// adrc_datapath
// Registers, envelope follower, restoring gain divider and mix multipliers.
// ----------------------------------------------------------------------------
module adrc_datapath
    import adrc_pkg::*;
#(
    parameter int ATTACK_DIVISOR  = 8,
    parameter int RELEASE_DIVISOR = 128
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  cfg_idx_t                   cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       last_in,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_out,
    input  adrc_cmd_t                  cmd,
    output adrc_stat_t                 stat
);

    // delta/D as delta*ceil(2^(16+l)/D) >> (16+l), l = clog2(D): exact for 16-bit delta
    localparam int ATK_SH  = ENV_W + $clog2(ATTACK_DIVISOR);
    localparam int REL_SH  = ENV_W + $clog2(RELEASE_DIVISOR);
    localparam int RECIP_W = ENV_W + 1;
    localparam int PROD_W  = ENV_W + RECIP_W;
    localparam logic [RECIP_W-1:0] ATK_RECIP = RECIP_W'(
        ((64'd1 << ATK_SH) + 64'(ATTACK_DIVISOR) - 64'd1) / 64'(ATTACK_DIVISOR));
    localparam logic [RECIP_W-1:0] REL_RECIP = RECIP_W'(
        ((64'd1 << REL_SH) + 64'(RELEASE_DIVISOR) - 64'd1) / 64'(RELEASE_DIVISOR));

    localparam int WET1_W = SAMPLE_W;
    localparam int WET2_W = SAMPLE_W + 2;
    localparam int ACC_W  = 2 * SAMPLE_W - 1;
    localparam int PWET_W = WET2_W + MIX_W + 1;
    localparam int SUM_W  = PWET_W + 1;
    localparam int RES_W  = SUM_W - MIX_FRAC;
    localparam int PMK_W  = WET1_W + MAKEUP_W + 1;

    // configuration
    logic [TSET_W-1:0]   thr_set_reg, thr_set_next;
    logic [MSET_W-1:0]   mk_set_reg, mk_set_next;
    logic [MIX_W-1:0]    mix_set_reg, mix_set_next;
    logic [THR_W-1:0]    thr_reg, thr_next;
    logic [MAKEUP_W-1:0] makeup_reg, makeup_next;

    // per-sample datapath
    logic signed [SAMPLE_W-1:0] dry_reg, dry_next;
    logic                       last_reg, last_next;
    logic                       att_reg, att_next;
    logic                       rel_reg, rel_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [ENV_W-1:0]           env_reg, env_next;
    logic [ENV_W-1:0]           rem_reg, rem_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic signed [WET1_W-1:0]   wet1_reg, wet1_next;
    logic signed [WET2_W-1:0]   wet2_reg, wet2_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                       out_last_reg, out_last_next;

    logic [TSET_W-1:0]   thr_clamp;
    logic [MSET_W-1:0]   mk_clamp;
    logic [MIX_W-1:0]    mix_clamp;
    logic [MIX_W-1:0]    dry_weight;
    logic [MSET_W+MAKEUP_RECIP_W-1:0] mk_prod;

    logic [SAMPLE_W:0]   mag;
    logic [ENV_W-1:0]    level;
    logic [ENV_W-1:0]    delta;
    logic [PROD_W-1:0]   q_wide;
    logic [ENV_W-1:0]    step;
    logic                above;
    logic [ENV_W-1:0]    over;
    logic [ENV_W-1:0]    comp;
    logic [ENV_W:0]      trial;
    logic                fits;

    logic signed [2*SAMPLE_W-1:0]          p_gain;
    logic signed [PMK_W-1:0]               p_makeup;
    logic signed [2*SAMPLE_W-1:0]          p_dry;
    logic signed [PWET_W-1:0]              p_wet;
    logic signed [RES_W-1:0]               res;

    // derived register values
    always_comb
    begin
        thr_clamp  = (thr_set_reg > TSET_W'(THR_SET_MAX)) ? TSET_W'(THR_SET_MAX) : thr_set_reg;
        mk_clamp   = (mk_set_reg > MSET_W'(MAKEUP_SET_MAX)) ? MSET_W'(MAKEUP_SET_MAX)
                                                             : mk_set_reg;
        mix_clamp  = (mix_set_reg > MIX_W'(MIX_MAX)) ? MIX_W'(MIX_MAX) : mix_set_reg;
        dry_weight = MIX_W'(MIX_FULL) - mix_clamp;
        mk_prod    = (MSET_W+MAKEUP_RECIP_W)'(mk_clamp)
                   * (MSET_W+MAKEUP_RECIP_W)'(MAKEUP_RECIP);
        thr_next    = THR_W'(THR_BASE) + THR_W'(THR_W'(thr_clamp) * THR_W'(THR_SCALE));
        makeup_next = MAKEUP_W'(MAKEUP_BASE)
                    + mk_prod[MSET_W+MAKEUP_RECIP_W-1 -: MAKEUP_W];
    end

    always_comb
    begin
        thr_set_next = thr_set_reg;
        mk_set_next  = mk_set_reg;
        mix_set_next = mix_set_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_set_next = cfg_data[TSET_W-1:0];
                CFG_MAKEUP:    mk_set_next  = cfg_data[MSET_W-1:0];
                CFG_WET_MIX:   mix_set_next = cfg_data[MIX_W-1:0];
                default:       ;
            endcase
        end
    end

    // envelope and gain arithmetic
    always_comb
    begin
        mag   = dry_reg[SAMPLE_W-1] ? (SAMPLE_W+1)'(0) - {dry_reg[SAMPLE_W-1], dry_reg}
                                    : {dry_reg[SAMPLE_W-1], dry_reg};
        level = mag[ENV_W-1:0];
        delta = (level > env_reg) ? level - env_reg : env_reg - level;

        q_wide = att_reg ? (prod_reg >> ATK_SH) : (prod_reg >> REL_SH);
        step   = (q_wide[ENV_W-1:0] == '0) ? ENV_W'(1) : q_wide[ENV_W-1:0];

        above = env_reg > {1'b0, thr_reg};
        over  = env_reg - {1'b0, thr_reg};
        comp  = {1'b0, thr_reg} + {2'b00, over[ENV_W-1:2]};

        trial = {rem_reg, 1'b0};
        fits  = trial >= {1'b0, env_reg};

        p_gain   = (2*SAMPLE_W)'(dry_reg) * (2*SAMPLE_W)'($signed({1'b0, gain_reg}));
        p_makeup = PMK_W'(wet1_reg) * PMK_W'($signed({1'b0, makeup_reg}));
        p_dry    = (2*SAMPLE_W)'(dry_reg) * (2*SAMPLE_W)'($signed({1'b0, dry_weight}));
        p_wet    = PWET_W'(wet2_reg) * PWET_W'($signed({1'b0, mix_clamp}));
        res      = sum_reg[SUM_W-1:MIX_FRAC];
    end

    assign stat.above = above;

    always_comb
    begin
        dry_next        = dry_reg;
        last_next       = last_reg;
        att_next        = att_reg;
        rel_next        = rel_reg;
        prod_next       = prod_reg;
        env_next        = env_reg;
        rem_next        = rem_reg;
        gain_next       = gain_reg;
        wet1_next       = wet1_reg;
        wet2_next       = wet2_reg;
        acc_next        = acc_reg;
        sum_next        = sum_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;

        if (cmd.capture)
        begin
            dry_next  = sample_in;
            last_next = last_in;
        end
        if (cmd.env_mul)
        begin
            att_next  = level > env_reg;
            rel_next  = level < env_reg;
            prod_next = PROD_W'(delta)
                      * PROD_W'((level > env_reg) ? ATK_RECIP : REL_RECIP);
        end
        if (cmd.env_upd)
        begin
            if (att_reg)
                env_next = env_reg + step;
            else if (rel_reg)
                env_next = env_reg - step;
        end
        if (cmd.gain_init)
        begin
            rem_next  = comp;
            gain_next = above ? '0 : GAIN_W'(GAIN_UNITY);
        end
        if (cmd.div_step)
        begin
            // one quotient bit of (comp << 15) / envelope
            rem_next  = fits ? ENV_W'(trial - {1'b0, env_reg}) : trial[ENV_W-1:0];
            gain_next = {gain_reg[GAIN_W-2:0], fits};
        end
        if (cmd.mul_gain)
            wet1_next = p_gain[GAIN_FRAC+WET1_W-1:GAIN_FRAC];
        if (cmd.mul_makeup)
            wet2_next = p_makeup[MAKEUP_FRAC+WET2_W-1:MAKEUP_FRAC];
        if (cmd.mul_dry)
            acc_next = p_dry[ACC_W-1:0];
        if (cmd.mac_wet)
            sum_next = SUM_W'(acc_reg) + SUM_W'(p_wet);
        if (cmd.load_out)
        begin
            if (res > RES_W'(signed'(MIX_FULL)))
                out_sample_next = SAMPLE_W'(signed'(MIX_FULL));
            else if (res < -RES_W'(signed'(MIX_FULL + 1)))
                out_sample_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
            else
                out_sample_next = res[SAMPLE_W-1:0];
            out_last_next = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_set_reg <= TSET_W'(THR_SET_RESET);
            mk_set_reg  <= MSET_W'(MAKEUP_SET_RESET);
            mix_set_reg <= MIX_W'(MIX_RESET);
            thr_reg     <= THR_W'(THR_RESET);
            makeup_reg  <= MAKEUP_W'(MAKEUP_RESET);
            env_reg     <= '0;
        end
        else
        begin
            thr_set_reg <= thr_set_next;
            mk_set_reg  <= mk_set_next;
            mix_set_reg <= mix_set_next;
            thr_reg     <= thr_next;
            makeup_reg  <= makeup_next;
            env_reg     <= env_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dry_reg        <= dry_next;
        last_reg       <= last_next;
        att_reg        <= att_next;
        rel_reg        <= rel_next;
        prod_reg       <= prod_next;
        rem_reg        <= rem_next;
        gain_reg       <= gain_next;
        wet1_reg       <= wet1_next;
        wet2_reg       <= wet2_next;
        acc_reg        <= acc_next;
        sum_reg        <= sum_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    assign sample_out = out_sample_reg;
    assign last_out   = out_last_reg;

endmodule

>>> rtl/adrc_ctrl.sv
// ----------------------------------------------------------------------------
// adrc_ctrl
// Sequencer for one sample: envelope, gain division (above the threshold only), multiplies, output.
// ----------------------------------------------------------------------------
module adrc_ctrl
    import adrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output adrc_cmd_t  cmd,
    input  adrc_stat_t stat
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE       = 4'd0;
    localparam logic [ST_W-1:0] ST_ENV_MUL    = 4'd1;
    localparam logic [ST_W-1:0] ST_ENV_UPD    = 4'd2;
    localparam logic [ST_W-1:0] ST_GAIN       = 4'd3;
    localparam logic [ST_W-1:0] ST_DIV        = 4'd4;
    localparam logic [ST_W-1:0] ST_MUL_GAIN   = 4'd5;
    localparam logic [ST_W-1:0] ST_MUL_MAKEUP = 4'd6;
    localparam logic [ST_W-1:0] ST_MUL_DRY    = 4'd7;
    localparam logic [ST_W-1:0] ST_MAC_WET    = 4'd8;
    localparam logic [ST_W-1:0] ST_FINISH     = 4'd9;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ENV_MUL;
                end
            end
            ST_ENV_MUL:
            begin
                cmd.env_mul = 1'b1;
                state_next  = ST_ENV_UPD;
            end
            ST_ENV_UPD:
            begin
                cmd.env_upd = 1'b1;
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.gain_init = 1'b1;
                cnt_next      = '0;
                state_next    = stat.above ? ST_DIV : ST_MUL_GAIN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_MUL_MAKEUP;
            end
            ST_MUL_MAKEUP:
            begin
                cmd.mul_makeup = 1'b1;
                state_next     = ST_MUL_DRY;
            end
            ST_MUL_DRY:
            begin
                cmd.mul_dry = 1'b1;
                state_next  = ST_MAC_WET;
            end
            ST_MAC_WET:
            begin
                cmd.mac_wet = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait here while the previous result is still unclaimed
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> tb/sv/tb_audio_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// tb_audio_dynamic_range_compressor
// Self-checking bench for the 4:1 feed-forward compressor. A short table of
// directed samples (full-scale runs, most negative value, silence, small
// levels) is followed by bursts of loud, quiet, random and edge samples under
// several register settings, including the clamped extremes. Every sample is
// run through a local envelope, gain, makeup and mix calculation; results are
// compared to it in order, pinned rows to their fixed value. Both ends of the
// sample path idle at random, and the result side is once held off at length.
// ----------------------------------------------------------------------------
module tb_audio_dynamic_range_compressor
    import adrc_pkg::*;
();

    localparam int ATTACK_DIV      = 8;
    localparam int RELEASE_DIV     = 128;
    localparam int RESET_CYCLES    = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int NUM_PHASES      = 7;
    localparam int PHASE_ITEMS     = 55;
    localparam int NUM_DIRECTED    = 21;

    // index past the end of the register list; writes to it are dropped
    localparam cfg_idx_t CFG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } comp_out_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       pinned;
        logic signed [SAMPLE_W-1:0] want;
    } dir_row_t;

    typedef enum int {
        BURST_LOUD,
        BURST_QUIET,
        BURST_ANY,
        BURST_EDGE
    } burst_t;

    logic clk;
    logic rst_n;

    adrc_sample_if smp_if ();
    adrc_result_if res_if ();
    adrc_cfg_if    cfg_if ();

    audio_dynamic_range_compressor #(
        .ATTACK_DIVISOR  (ATTACK_DIV),
        .RELEASE_DIVISOR (RELEASE_DIV)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (smp_if),
        .result_ch (res_if),
        .cfg_ch    (cfg_if)
    );

    // local copy of the block's state and registers
    logic [ENV_W-1:0]  env_level;
    logic [TSET_W-1:0] thr_set;
    logic [MSET_W-1:0] makeup_set;
    logic [MIX_W-1:0]  wet_set;

    comp_out_t   due_q[$];
    int unsigned mismatches;
    int unsigned src_gap_pct;
    int unsigned sink_gap_pct;
    bit          hold_req;

    // pinned rows: silence gives silence, full scale saturates straight after reset
    dir_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{16'sd0,     1'b0, 1'b1, 16'sd0},
        '{16'sd32767, 1'b0, 1'b1, 16'sd32767},
        '{16'h8000,   1'b0, 1'b1, 16'h8000},
        '{16'sd32767, 1'b0, 1'b0, 16'sd0},
        '{16'h8000,   1'b0, 1'b0, 16'sd0},
        '{16'sd32767, 1'b0, 1'b0, 16'sd0},
        '{16'h8000,   1'b0, 1'b0, 16'sd0},
        '{16'sd32767, 1'b0, 1'b0, 16'sd0},
        '{16'sd32767, 1'b1, 1'b0, 16'sd0},
        '{16'sd0,     1'b0, 1'b1, 16'sd0},
        '{16'sd1,     1'b0, 1'b0, 16'sd0},
        '{16'hFFFF,   1'b0, 1'b0, 16'sd0},
        '{16'sd100,   1'b0, 1'b0, 16'sd0},
        '{16'hFF9C,   1'b1, 1'b0, 16'sd0},
        '{16'h5555,   1'b0, 1'b0, 16'sd0},
        '{16'hAAAA,   1'b0, 1'b0, 16'sd0},
        '{16'sd16384, 1'b0, 1'b0, 16'sd0},
        '{16'hBFFF,   1'b0, 1'b0, 16'sd0},
        '{16'sd0,     1'b1, 1'b1, 16'sd0},
        '{16'sd2,     1'b0, 1'b0, 16'sd0},
        '{16'h7FFE,   1'b1, 1'b0, 16'sd0}
    };

    // envelope follower, 4:1 gain above threshold, makeup, dry/wet mix
    function automatic comp_out_t compress_sample(input logic signed [SAMPLE_W-1:0] dry_in,
                                                  input logic last);
        longint    dry, level, env, thr, makeup, mix, gain, wet, sum, step;
        longint    tset, mset;
        comp_out_t res;

        dry   = dry_in;
        level = (dry < 0) ? -dry : dry;
        env   = env_level;

        tset = thr_set;
        if (tset > THR_SET_MAX)
            tset = THR_SET_MAX;
        mset = makeup_set;
        if (mset > MAKEUP_SET_MAX)
            mset = MAKEUP_SET_MAX;
        mix = wet_set;
        if (mix > MIX_MAX)
            mix = MIX_MAX;

        thr    = THR_BASE + tset * 22000 / 1000;
        makeup = MAKEUP_BASE + mset * 8192 / 32000;

        if (level > env)
        begin
            step = (level - env) / ATTACK_DIV;
            if (step == 0)
                step = 1;
            env = env + step;
        end
        else if (level < env)
        begin
            step = (env - level) / RELEASE_DIV;
            if (step == 0)
                step = 1;
            env = env - step;
        end
        env_level = env[ENV_W-1:0];
        env       = env_level;

        gain = GAIN_UNITY;
        if (env > thr)
            gain = ((thr + (env - thr) / 4) << GAIN_FRAC) / env;

        wet = (dry * gain) >>> GAIN_FRAC;
        wet = (wet * makeup) >>> MAKEUP_FRAC;
        sum = (dry * (MIX_FULL - mix) + wet * mix) >>> MIX_FRAC;
        if (sum > 32767)
            sum = 32767;
        if (sum < -32768)
            sum = -32768;

        res.sample = sum[SAMPLE_W-1:0];
        res.last   = last;
        return res;
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last,
                               input logic pinned, input logic signed [SAMPLE_W-1:0] want);
        comp_out_t due;
        while ($urandom_range(99) < src_gap_pct)
        begin
            smp_if.valid <= 1'b0;
            @(posedge clk);
        end
        smp_if.valid     <= 1'b1;
        smp_if.sample_in <= s;
        smp_if.last_in   <= last;
        do
            @(posedge clk);
        while (!smp_if.ready);
        due = compress_sample(s, last);
        if (pinned)
            due.sample = want;
        due_q.push_back(due);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        smp_if.valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            CFG_THRESHOLD: thr_set    = val[TSET_W-1:0];
            CFG_MAKEUP:    makeup_set = val[MSET_W-1:0];
            CFG_WET_MIX:   wet_set    = val[MIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr_val,
                                  input logic [CFG_DATA_W-1:0] makeup_val,
                                  input logic [CFG_DATA_W-1:0] mix_val);
        write_reg(CFG_THRESHOLD, thr_val);
        write_reg(CFG_MAKEUP, makeup_val);
        write_reg(CFG_WET_MIX, mix_val);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(input burst_t kind);
        int v;
        case (kind)
            BURST_LOUD:
            begin
                v = $urandom_range(32768, 16000);
                if ($urandom_range(1))
                    v = -v;
                else if (v > 32767)
                    v = 32767;
            end
            BURST_QUIET:
                v = int'($urandom_range(1200)) - 600;
            BURST_EDGE:
                case ($urandom_range(4))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            default:
                v = $urandom;
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    // loud bursts dominate so the envelope spends time above the threshold
    task automatic run_bursts(input int count);
        burst_t kind;
        int     left;
        int     pick;
        left = 0;
        kind = BURST_LOUD;
        repeat (count)
        begin
            if (left == 0)
            begin
                pick = $urandom_range(9);
                if (pick < 5)
                    kind = BURST_LOUD;
                else if (pick < 7)
                    kind = BURST_QUIET;
                else if (pick < 9)
                    kind = BURST_ANY;
                else
                    kind = BURST_EDGE;
                left = $urandom_range(40, 8);
            end
            left--;
            send_sample(draw_sample(kind), ($urandom_range(7) == 0), 1'b0, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400_000);
        $display("Regression FAIL");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        int n;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(posedge clk);
            end
            res_if.ready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        comp_out_t due;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (due_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got sample %0d last %0b",
                         $time, res_if.sample_out, res_if.last_out);
            end
            else
            begin
                due = due_q.pop_front();
                if (res_if.sample_out !== due.sample)
                begin
                    mismatches++;
                    $display("%0t: sample_out expected %0d, got %0d",
                             $time, due.sample, res_if.sample_out);
                end
                if (res_if.last_out !== due.last)
                begin
                    mismatches++;
                    $display("%0t: last_out expected %0b, got %0b",
                             $time, due.last, res_if.last_out);
                end
            end
        end
    end

    initial
    begin
        int ph;
        rst_n            <= 1'b0;
        smp_if.valid     <= 1'b0;
        smp_if.sample_in <= '0;
        smp_if.last_in   <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_THRESHOLD;
        cfg_if.data      <= '0;
        env_level    = '0;
        thr_set      = THR_SET_RESET;
        makeup_set   = MAKEUP_SET_RESET;
        wet_set      = MIX_RESET;
        mismatches   = 0;
        src_gap_pct  = 32;
        sink_gap_pct = 59;
        hold_req     = 1'b0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_sample(directed_rows[i].sample, directed_rows[i].last,
                        directed_rows[i].pinned, directed_rows[i].want);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            if (ph == 3)
            begin
                src_gap_pct  = 59;
                sink_gap_pct = 32;
            end
            else if (ph == 5)
            begin
                src_gap_pct  = 0;
                sink_gap_pct = 0;
            end
            case (ph)
                0: apply_settings(15'd0, 15'd0, 15'd32000);
                1: apply_settings(15'd1000, 15'd32000, 15'd32000);
                2: apply_settings(15'h7FFF, 15'h7FFF, 15'h7FFF);
                3: apply_settings(15'd500, 15'd16000, 15'd0);
                4: apply_settings(15'd0, 15'd32000, 15'd16384);
                default: apply_settings(15'($urandom), 15'($urandom), 15'($urandom));
            endcase
            // fill the block behind a stalled result port
            if (ph == 1)
                hold_req = 1'b1;
            run_bursts(PHASE_ITEMS);
        end

        drain();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && due_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
